>>> design/pip_pkg.sv
// Shared types and codes for the point-in-polygon test block.
package pip_pkg;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED,
		ST_WALK,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// Sequencer to edge datapath, aligned with the RAM read data
	typedef struct packed {
		logic clear;     // query accepted: latch point, zero parity
		logic seed_vld;  // read data is the closing vertex (j of the first edge)
		logic edge_vld;  // read data is vertex i of an edge
	} ctrl_t;

endpackage

>>> design/pip_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module pip_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> design/pip_ctrl.sv
// Query sequencer: issues vertex reads for one query and frames the result beat.
module pip_ctrl
	import pip_pkg::*;
#(
	parameter int MAX_VERTICES = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            query_go,
	input  logic [6:0]                      vertex_count,
	input  logic                            dp_busy,
	output logic                            busy,
	output logic                            done,
	output logic                            rd_en,
	output logic [$clog2(MAX_VERTICES)-1:0] rd_addr,
	output ctrl_t                           ctrl
);

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);

	state_t          state_q, state_d;
	logic [CW-1:0]   n_q;
	logic [CW-1:0]   n_m1;
	logic [AW-1:0]   idx_q;
	logic            last_idx;
	logic            seed_q, edge_q;
	logic [CW-1:0]   n_clamp;

	assign n_clamp = (32'(vertex_count) > MAX_VERTICES) ? CW'(MAX_VERTICES)
	                                                     : CW'(vertex_count);
	assign n_m1     = n_q - CW'(1);
	assign last_idx = (CW'(idx_q) == n_m1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (query_go) begin
					state_d = (n_clamp == '0) ? ST_DONE : ST_SEED;
				end
			end
			ST_SEED:  state_d = ST_WALK;
			ST_WALK: begin
				if (last_idx) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!edge_q && !dp_busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy    = 1'b1;
		done    = 1'b0;
		rd_en   = 1'b0;
		rd_addr = idx_q;
		case (state_q)
			ST_IDLE:  busy = 1'b0;
			ST_SEED: begin
				rd_en   = 1'b1;
				rd_addr = n_m1[AW-1:0];
			end
			ST_WALK:  rd_en = 1'b1;
			ST_DRAIN: rd_en = 1'b0;
			ST_DONE:  done = 1'b1;
			default:  busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= '0;
			idx_q   <= '0;
			seed_q  <= 1'b0;
			edge_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			seed_q  <= (state_q == ST_SEED);
			edge_q  <= (state_q == ST_WALK);
			if (state_q == ST_IDLE && query_go) begin
				n_q <= n_clamp;
			end
			if (state_q == ST_WALK) begin
				idx_q <= idx_q + AW'(1);
			end else begin
				idx_q <= '0;
			end
		end
	end

	assign ctrl.clear    = (state_q == ST_IDLE) && query_go;
	assign ctrl.seed_vld = seed_q;
	assign ctrl.edge_vld = edge_q;

endmodule

>>> design/pip_edge.sv
// Edge datapath: straddle test, cross-multiplied crossing compare, parity.
module pip_edge
	import pip_pkg::*;
#(
	parameter int COORD_BITS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ctrl_t                     ctrl,
	input  logic [COORD_BITS-1:0]     point_x,
	input  logic [COORD_BITS-1:0]     point_y,
	input  logic [2*COORD_BITS-1:0]   rd_data,
	output logic                      dp_busy,
	output logic                      parity
);

	localparam int CB = COORD_BITS;
	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * DW;

	logic signed [CB-1:0] px_q, py_q, xj_q, yj_q;
	logic signed [CB-1:0] xi, yi;
	logic signed [DW-1:0] a, b, c, dy;
	logic                 straddle;

	logic signed [DW-1:0] a_s1, b_s1, c_s1, dy_s1;
	logic                 v_s1;
	logic signed [PW-1:0] lhs_s2, rhs_s2;
	logic                 dypos_s2, v_s2;
	logic                 parity_q;
	logic                 left;

	assign xi = rd_data[CB-1:0];
	assign yi = rd_data[2*CB-1:CB];

	assign a  = DW'(px_q) - DW'(xi);
	assign b  = DW'(xj_q) - DW'(xi);
	assign c  = DW'(py_q) - DW'(yi);
	assign dy = DW'(yj_q) - DW'(yi);
	assign straddle = (yi > py_q) != (yj_q > py_q);

	// dy is never zero on a straddling edge, so its sign bit picks the direction
	assign left = dypos_s2 ? (lhs_s2 < rhs_s2) : (rhs_s2 < lhs_s2);

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			px_q <= point_x;
			py_q <= point_y;
		end
		if (ctrl.seed_vld || ctrl.edge_vld) begin
			xj_q <= xi;
			yj_q <= yi;
		end
		a_s1     <= a;
		b_s1     <= b;
		c_s1     <= c;
		dy_s1    <= dy;
		lhs_s2   <= PW'(a_s1) * PW'(dy_s1);
		rhs_s2   <= PW'(b_s1) * PW'(c_s1);
		dypos_s2 <= !dy_s1[DW-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			parity_q <= 1'b0;
		end else begin
			v_s1 <= ctrl.edge_vld && straddle;
			v_s2 <= v_s1;
			if (ctrl.clear) begin
				parity_q <= 1'b0;
			end else if (v_s2 && left) begin
				parity_q <= !parity_q;
			end
		end
	end

	assign dp_busy = v_s1 || v_s2;
	assign parity  = parity_q;

endmodule

>>> design/point_in_polygon_test.sv
// Top level of the point-in-polygon test block.
//
// Polygon vertices live in one synchronous RAM of MAX_VERTICES entries and are
// written one beat at a time (operation = write, vertex_index, coord_x/coord_y);
// a write leaves busy low. A query beat walks the closed
// polygon of the first vertex_count vertices with the even-odd crossing rule
// and answers with one done beat carrying inside_res; busy is high while it
// runs. A query with n vertices in use keeps the block busy for one read of
// the closing vertex, n reads of the RAM port (one edge each), a drain that
// waits for straddling edges still in the difference, multiply and compare
// stages, and the result cycle. With zero vertices the answer is outside.
// The done strobe lasts exactly one cycle and cannot be held off: capture it.
// Counts above MAX_VERTICES are clamped, writes to slots beyond it are dropped,
// and a query must not touch a slot that was never written.
module point_in_polygon_test
	import pip_pkg::*;
#(
	parameter int MAX_VERTICES = 64,
	parameter int COORD_BITS   = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        operation,
	input  logic [5:0]  vertex_index,
	input  logic [31:0] coord_x,
	input  logic [31:0] coord_y,
	output logic        done,
	output logic        inside_res,
	input  logic        vertex_count_we,
	input  logic [6:0]  vertex_count
);

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int IW = (AW > 6) ? AW : 6;
	localparam int VW = 2 * COORD_BITS;

	logic [6:0]    vcount_q;
	logic          accept;
	logic          wr_en;
	logic [IW-1:0] idx_ext;
	logic [AW-1:0] wr_addr;
	logic [VW-1:0] wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [VW-1:0] rd_data;
	logic          dp_busy;
	logic          parity;
	ctrl_t         ctrl;

	// Vertex count register; the user must write it only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= '0;
		end else if (vertex_count_we) begin
			vcount_q <= vertex_count;
		end
	end

	assign accept  = start && !busy;
	assign idx_ext = IW'(vertex_index);
	assign wr_addr = idx_ext[AW-1:0];
	// Drop writes to slots past the RAM depth
	assign wr_en   = accept && (operation == OP_WRITE) && (32'(vertex_index) < MAX_VERTICES);
	assign wr_data = {coord_y[COORD_BITS-1:0], coord_x[COORD_BITS-1:0]};

	pip_ram #(
		.WIDTH (VW),
		.DEPTH (MAX_VERTICES)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	pip_ctrl #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.query_go     (start && (operation == OP_QUERY)),
		.vertex_count (vcount_q),
		.dp_busy      (dp_busy),
		.busy         (busy),
		.done         (done),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.ctrl         (ctrl)
	);

	pip_edge #(
		.COORD_BITS (COORD_BITS)
	) u_edge (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.point_x (coord_x[COORD_BITS-1:0]),
		.point_y (coord_y[COORD_BITS-1:0]),
		.rd_data (rd_data),
		.dp_busy (dp_busy),
		.parity  (parity)
	);

	// Parity is final by the result cycle; it reads zero for an empty polygon
	assign inside_res = parity;

endmodule

>>> tb/pip_checker.sv
// Checker for the point-in-polygon block: tracks vertices and count, predicts and compares results.
module pip_checker
	import pip_pkg::*;
#(
	parameter int MAX_VERTICES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        operation,
	input  logic [5:0]  vertex_index,
	input  logic [31:0] coord_x,
	input  logic [31:0] coord_y,
	input  logic        done,
	input  logic        inside_res,
	input  logic        vertex_count_we,
	input  logic [6:0]  vertex_count,
	output int          fail_count,
	output int          pending,
	output int          query_count,
	output int          inside_count
);

	longint     vert_x [MAX_VERTICES];
	longint     vert_y [MAX_VERTICES];
	logic [6:0] poly_count;
	logic       inside_q [$];
	logic       want_inside;

	// Even-odd crossing rule with the crossing test cross-multiplied at 70 bits.
	function automatic logic predict_inside(logic signed [31:0] qx, logic signed [31:0] qy);
		int                n;
		int                j;
		longint            px;
		longint            py;
		longint            dy;
		logic signed [69:0] dpx;
		logic signed [69:0] ddy;
		logic signed [69:0] dxe;
		logic signed [69:0] dpy;
		logic signed [69:0] lhs;
		logic signed [69:0] rhs;
		logic              odd;
		logic              left;
		n = (poly_count > MAX_VERTICES) ? MAX_VERTICES : int'(poly_count);
		px = qx;
		py = qy;
		odd = 1'b0;
		j = n - 1;
		for (int i = 0; i < n; i++) begin
			if ((vert_y[i] > py) != (vert_y[j] > py)) begin
				dy = vert_y[j] - vert_y[i];
				dpx = px - vert_x[i];
				ddy = dy;
				dxe = vert_x[j] - vert_x[i];
				dpy = py - vert_y[i];
				lhs = dpx * ddy;
				rhs = dxe * dpy;
				left = (dy > 0) ? (lhs < rhs) : (rhs < lhs);
				if (left)
					odd = ~odd;
			end
			j = i;
		end
		return odd;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_count = '0;
			inside_q.delete();
			fail_count = 0;
			pending = 0;
			query_count = 0;
			inside_count = 0;
			for (int k = 0; k < MAX_VERTICES; k++) begin
				vert_x[k] = 0;
				vert_y[k] = 0;
			end
		end else begin
			// Retire the result first, before this edge's count write or new beat.
			if (done) begin
				if (inside_res === 1'b1)
					inside_count++;
				if (inside_q.size() == 0) begin
					$display("%0t: result with no query outstanding, expected none, got %0b",
						$time, inside_res);
					fail_count++;
				end else begin
					want_inside = inside_q.pop_front();
					if (inside_res !== want_inside) begin
						$display("%0t: inside_res mismatch, expected %0b, got %0b",
							$time, want_inside, inside_res);
						fail_count++;
					end
				end
			end
			if (vertex_count_we)
				poly_count = vertex_count;
			if (start && !busy) begin
				if (operation == OP_QUERY) begin
					inside_q.push_back(predict_inside(coord_x, coord_y));
					query_count++;
				end else if (vertex_index < MAX_VERTICES) begin
					vert_x[vertex_index] = longint'($signed(coord_x));
					vert_y[vertex_index] = longint'($signed(coord_y));
				end
			end
			pending = inside_q.size();
		end
	end

endmodule

>>> tb/tb_top.sv
// Stimulus and verdict for the point-in-polygon block, with the checker beside it.
module tb_top
	import pip_pkg::*;
();

	localparam int ITEM_TARGET = 1900;
	// From here on the sender inserts no random idle gaps.
	localparam int QUIET_FROM  = 1700;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        operation = OP_WRITE;
	logic [5:0]  vertex_index = '0;
	logic [31:0] coord_x = '0;
	logic [31:0] coord_y = '0;
	logic        done;
	logic        inside_res;
	logic        vertex_count_we = 1'b0;
	logic [6:0]  vertex_count = '0;

	int fail_count;
	int pending;
	int query_count;
	int inside_count;

	// Our own copy of the vertex table, used to aim query points and to repeat earlier vertices.
	logic signed [31:0] poly_x [64];
	logic signed [31:0] poly_y [64];

	int items_sent = 0;
	int write_beats = 0;
	int count_writes = 0;

	point_in_polygon_test DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.operation       (operation),
		.vertex_index    (vertex_index),
		.coord_x         (coord_x),
		.coord_y         (coord_y),
		.done            (done),
		.inside_res      (inside_res),
		.vertex_count_we (vertex_count_we),
		.vertex_count    (vertex_count)
	);

	pip_checker check (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.operation       (operation),
		.vertex_index    (vertex_index),
		.coord_x         (coord_x),
		.coord_y         (coord_y),
		.done            (done),
		.inside_res      (inside_res),
		.vertex_count_we (vertex_count_we),
		.vertex_count    (vertex_count),
		.fail_count      (fail_count),
		.pending         (pending),
		.query_count     (query_count),
		.inside_count    (inside_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop: far beyond the slowest legal run.
	initial begin
		#8_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// Random point within +/- 2^s of c; wrap the sum to 32 bits.
	function automatic logic [31:0] near(longint c, int s);
		longint off;
		off = longint'($signed($urandom)) >>> (31 - s);
		return 32'(c + off);
	endfunction

	// One of the corner values of a signed 32-bit coordinate.
	function automatic logic [31:0] corner_value();
		case ($urandom_range(0, 3))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	// Present one beat and hold it until the block takes it. Busy only moves on the
	// rising edge, so sample it at the falling edge before deciding the beat went in.
	// Leave start high on return: the caller either presents the next beat or drops it.
	task automatic send_beat(input logic op, input logic [5:0] idx,
			input logic [31:0] x, input logic [31:0] y);
		logic taken;
		if (items_sent < QUIET_FROM && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		start <= 1'b1;
		operation <= op;
		vertex_index <= idx;
		coord_x <= x;
		coord_y <= y;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end
		items_sent++;
		if (op == OP_WRITE) begin
			poly_x[idx] = x;
			poly_y[idx] = y;
			write_beats++;
		end
	endtask

	// Drop start and wait until every query has answered and the block is quiet.
	task automatic wait_idle();
		logic quiet;
		start <= 1'b0;
		quiet = 1'b0;
		while (!quiet) begin
			@(negedge clk);
			quiet = (pending == 0) && !busy;
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
	endtask

	// Write the vertex count only while the block is idle.
	task automatic set_count(input logic [6:0] value);
		wait_idle();
		vertex_count_we <= 1'b1;
		vertex_count <= value;
		@(posedge clk);
		vertex_count_we <= 1'b0;
		count_writes++;
	endtask

	initial begin
		int         phase;
		int         n;
		int         nw;
		int         s;
		int         nq;
		int         a;
		int         b;
		longint     cx;
		longint     cy;
		longint     mid;
		logic [31:0] qx;
		logic [31:0] qy;
		logic [31:0] wx;
		logic [31:0] wy;

		for (int k = 0; k < 64; k++) begin
			poly_x[k] = '0;
			poly_y[k] = '0;
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero vertices after reset must answer outside, whatever the point.
		send_beat(OP_QUERY, 6'd0, 32'h0000_0000, 32'h0000_0000);
		send_beat(OP_QUERY, 6'h3F, 32'h8000_0000, 32'h7FFF_FFFF);

		// Square of side 2 around the origin in Q16.16; probe the center, outside, a vertex, both vertical
		// edges and the y of both horizontal edges.
		send_beat(OP_WRITE, 6'd0, 32'hFFFF_0000, 32'hFFFF_0000);
		send_beat(OP_WRITE, 6'd1, 32'h0001_0000, 32'hFFFF_0000);
		send_beat(OP_WRITE, 6'd2, 32'h0001_0000, 32'h0001_0000);
		send_beat(OP_WRITE, 6'd3, 32'hFFFF_0000, 32'h0001_0000);
		set_count(7'd4);
		send_beat(OP_QUERY, 6'd0, 32'h0000_0000, 32'h0000_0000);
		send_beat(OP_QUERY, 6'd0, 32'h0002_0000, 32'h0000_0000);
		send_beat(OP_QUERY, 6'd0, 32'hFFFF_0000, 32'hFFFF_0000);
		send_beat(OP_QUERY, 6'd0, 32'hFFFF_0000, 32'h0000_0000);
		send_beat(OP_QUERY, 6'd0, 32'h0001_0000, 32'h0000_0000);
		send_beat(OP_QUERY, 6'd0, 32'h0000_0000, 32'hFFFF_0000);
		send_beat(OP_QUERY, 6'd0, 32'h0000_0000, 32'h0001_0000);

		// Triangle spanning the full coordinate range, plus the top slot written.
		send_beat(OP_WRITE, 6'd0, 32'h8000_0000, 32'h8000_0000);
		send_beat(OP_WRITE, 6'd1, 32'h7FFF_FFFF, 32'h8000_0000);
		send_beat(OP_WRITE, 6'd2, 32'h0000_0000, 32'h7FFF_FFFF);
		send_beat(OP_WRITE, 6'h3F, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		set_count(7'd3);
		send_beat(OP_QUERY, 6'd0, 32'h0000_0000, 32'h0000_0000);
		send_beat(OP_QUERY, 6'h3F, 32'h8000_0000, 32'h7FFF_FFFF);
		send_beat(OP_QUERY, 6'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_beat(OP_QUERY, 6'd0, 32'hFFFF_FFFF, 32'h0000_0000);
		send_beat(OP_QUERY, 6'd0, 32'h7FFF_FFFF, 32'h8000_0000);

		// Random phases: build a polygon, set the count, then query around it.
		// The first two phases use every slot, once exactly at capacity and once
		// with the count at its top value so that clamping is exercised.
		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			if (phase == 0)
				n = 64;
			else if (phase == 1)
				n = 127;
			else begin
				a = $urandom_range(0, 99);
				if (a < 5)
					n = 0;
				else if (a < 10)
					n = $urandom_range(1, 2);
				else if (a < 80)
					n = $urandom_range(3, 10);
				else if (a < 92)
					n = $urandom_range(11, 32);
				else if (a < 96)
					n = 64;
				else
					n = $urandom_range(65, 127);
			end
			nw = (n > 64) ? 64 : n;

			case ($urandom_range(0, 3))
				0: s = $urandom_range(2, 8);
				1: s = $urandom_range(14, 20);
				2: s = $urandom_range(24, 29);
				default: s = 31;
			endcase
			if (s >= 29) begin
				cx = 0;
				cy = 0;
			end else begin
				cx = longint'($signed($urandom)) >>> $urandom_range(1, 31);
				cy = longint'($signed($urandom)) >>> $urandom_range(1, 31);
			end

			// Fill every slot the count will read; now and then repeat the previous
			// y for a horizontal edge, or the whole vertex for a zero-length edge.
			for (int k = 0; k < nw; k++) begin
				wx = near(cx, s);
				wy = near(cy, s);
				if (k > 0 && $urandom_range(0, 7) == 0)
					wy = poly_y[k - 1];
				if (k > 0 && $urandom_range(0, 15) == 0) begin
					wx = poly_x[k - 1];
					wy = poly_y[k - 1];
				end
				send_beat(OP_WRITE, 6'(k), wx, wy);
			end
			set_count(7'(n));

			nq = (nw >= 32) ? $urandom_range(3, 8) : $urandom_range(6, 24);
			for (int q = 0; q < nq; q++) begin
				// Noise: overwrite any slot with an arbitrary vertex.
				if ($urandom_range(0, 9) == 0)
					send_beat(OP_WRITE, 6'($urandom_range(0, 63)), $urandom, $urandom);

				qx = near(cx, s);
				qy = near(cy, s);
				if (nw > 0) begin
					a = $urandom_range(0, nw - 1);
					b = (a == 0) ? nw - 1 : a - 1;
				end else begin
					a = 0;
					b = 0;
				end
				case ($urandom_range(0, 9))
					4: if (nw > 0) begin
						qx = poly_x[a];
						qy = poly_y[a];
					end
					5: if (nw > 0)
						qy = poly_y[a];
					6: if (nw > 0) begin
						mid = (longint'(poly_x[a]) + longint'(poly_x[b])) >>> 1;
						qx = 32'(mid);
						mid = (longint'(poly_y[a]) + longint'(poly_y[b])) >>> 1;
						qy = 32'(mid);
					end
					7: begin
						qx = $urandom;
						qy = $urandom;
					end
					8: begin
						qx = corner_value();
						qy = corner_value();
					end
					9: if (nw > 0)
						qx = poly_x[a];
					default: ;
				endcase
				send_beat(OP_QUERY, 6'($urandom_range(0, 63)), qx, qy);
			end
			phase++;
		end

		// Drain: every answer in, then allow a full walk of latency on top.
		wait_idle();
		repeat (80) @(posedge clk);

		$display("Covered %0d beats in %0d phases: %0d vertex writes, %0d count writes,",
			items_sent, phase, write_beats, count_writes);
		$display("and %0d queries, of which %0d answered inside; %0d mismatches.",
			query_count, inside_count, fail_count);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
